[rtl/imhq_pkg.sv]
// imhq_pkg: types, constants and codes for the indexed min-heap queue
// no dependencies
package imhq_pkg;
	localparam int Depth = 1024;
	localparam int AddrW = 10;
	localparam int CountW = 11;

	typedef enum logic [2:0] {
		MODE_INSERT  = 3'd0,
		MODE_EXTRACT = 3'd1,
		MODE_DECR    = 3'd2,
		MODE_DELETE  = 3'd3,
		MODE_FIND    = 3'd4,
		MODE_SETPREV = 3'd5,
		MODE_PEEK    = 3'd6,
		MODE_NONE    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] vertex;
		logic [31:0] distance;
		logic [15:0] prev;
	} entry_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [9:0]  in_slot;
		logic [15:0] in_vertex;
		logic [31:0] in_dist;
		logic [15:0] in_prev;
	} req_t;

	typedef struct packed {
		logic [15:0] out_vertex;
		logic [31:0] out_dist;
		logic [15:0] out_prev;
		logic [9:0]  out_slot;
		logic        out_found;
		logic [10:0] entry_count;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic                 we;
		logic [AddrW-1:0]     waddr;
		entry_t               wdata;
		logic [AddrW-1:0]     raddr;
	} mem_req_t;
endpackage

[rtl/imhq_ram.sv]
// imhq_ram: single-port-write, single-read synchronous entry memory
// depends on imhq_pkg
module imhq_ram (
	input  logic               clk,
	input  imhq_pkg::mem_req_t mreq,
	output imhq_pkg::entry_t   rdata
);
	imhq_pkg::entry_t mem [imhq_pkg::Depth];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		rdata <= mem[mreq.raddr];
	end
endmodule

[rtl/indexed_min_heap_queue.sv]
// indexed_min_heap_queue: top level, heap sequencer around the entry memory
// depends on imhq_pkg and imhq_ram
//
// usage: pulse start with req while busy is low; the item is taken at that edge.
// busy stays high until the result; done strobes for one cycle with rsp and
// the receiver cannot stall it. busy falls with done, so a new item can be
// issued the cycle done is seen.
// work per request: a refused or unused request goes straight to the result;
// set predecessor reads, then rewrites the slot; peek rereads the root; insert
// and decrease climb one level per parent read; extract reads the root and the
// last entry, then sinks it one level per pair of child reads; delete first
// forces a climb to the root, then runs the extract path. find reads one slot
// at a time up to a match or entry_count slots. all cost is set by the single
// memory read port and its registered read data.
// cfg: cfg_valid/cfg_ready write capacity_in_use, taken only while idle.
// reset: count goes to zero, capacity to 1024; memory contents are not cleared
// and no clearing pass is needed.
module indexed_min_heap_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  imhq_pkg::req_t    req,
	output logic              done,
	output imhq_pkg::rsp_t    rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [10:0]       cfg_data
);
	localparam int AW = imhq_pkg::AddrW;
	localparam int CW = imhq_pkg::CountW;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_RD    = 14'b00000000000010,
		S_UPA   = 14'b00000000000100,
		S_UPB   = 14'b00000000001000,
		S_UPC   = 14'b00000000010000,
		S_RT0   = 14'b00000000100000,
		S_RT1   = 14'b00000001000000,
		S_DNA   = 14'b00000010000000,
		S_DNB   = 14'b00000100000000,
		S_DNC   = 14'b00001000000000,
		S_FIND  = 14'b00010000000000,
		S_FWAIT = 14'b00100000000000,
		S_PEEK  = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t            state_q;
	imhq_pkg::req_t    req_q;
	logic [CW-1:0]     count_q, cap_q, scan_q;
	logic [AW-1:0]     pos_q, sel_q;
	imhq_pkg::entry_t  cur_q, lch_q;
	logic              force_q, has_l_q, found_q;
	logic [AW-1:0]     fslot_q;
	imhq_pkg::entry_t  res_q;
	logic [1:0]        stat_q;
	imhq_pkg::mem_req_t mreq;
	imhq_pkg::entry_t  rdata;
	logic [CW-1:0]     cap_eff, child_l, child_r;
	logic [AW-1:0]     parent;
	logic              dn_left, dn_right;

	imhq_ram u_ram (.clk(clk), .mreq(mreq), .rdata(rdata));

	assign cap_eff = (cap_q > CW'(imhq_pkg::Depth)) ? CW'(imhq_pkg::Depth) : cap_q;
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign child_l = {pos_q, 1'b1};
	assign child_r = {pos_q, 1'b0} + CW'(2);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	// left child smaller than the moving entry, right child smaller than both
	assign dn_left  = has_l_q && (rdata.distance < cur_q.distance);
	assign dn_right = (child_r < count_q) && (rdata.distance <
		((sel_q == pos_q) ? cur_q.distance : lch_q.distance));

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE:  mreq.raddr = req.in_slot;
			S_UPA:   mreq.raddr = parent;
			S_RT0:   mreq.raddr = AW'(count_q - CW'(1));
			S_DNA:   mreq.raddr = child_l[AW-1:0];
			S_DNB:   mreq.raddr = child_r[AW-1:0];
			S_FIND:  mreq.raddr = scan_q[AW-1:0];
			default: mreq.raddr = '0;
		endcase
		unique case (state_q)
			S_RD: begin
				if (req_q.mode == imhq_pkg::MODE_SETPREV) begin
					mreq.we = 1'b1;
					mreq.waddr = pos_q;
					mreq.wdata = rdata;
					mreq.wdata.prev = req_q.in_prev;
				end
			end
			S_UPC: begin
				mreq.we = 1'b1;
				mreq.waddr = pos_q;
				mreq.wdata = cur_q;
			end
			S_DNC: begin
				mreq.we = 1'b1;
				mreq.waddr = pos_q;
				if (dn_right) mreq.wdata = rdata;
				else if (sel_q != pos_q) mreq.wdata = lch_q;
				else mreq.wdata = cur_q;
			end
			S_UPB: begin
				if (force_q || (rdata.distance > cur_q.distance)) begin
					mreq.we = 1'b1;
					mreq.waddr = pos_q;
					mreq.wdata = rdata;
				end
			end
			S_DNB: begin
				mreq.we = 1'b0;
			end
			default: mreq.we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cap_q   <= CW'(imhq_pkg::Depth);
			done    <= 1'b0;
			rsp     <= '0;
			req_q   <= '0;
			res_q   <= '0;
			stat_q  <= imhq_pkg::ST_OK;
			found_q <= 1'b0;
			fslot_q <= '0;
			scan_q  <= '0;
			pos_q   <= '0;
			sel_q   <= '0;
			force_q <= 1'b0;
			has_l_q <= 1'b0;
			cur_q   <= '0;
			lch_q   <= '0;
		end else begin
			done <= (state_q == S_DONE);
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						res_q   <= '0;
						found_q <= 1'b0;
						fslot_q <= '0;
						scan_q  <= '0;
						force_q <= 1'b0;
						unique case (req.mode)
							imhq_pkg::MODE_INSERT: begin
								if (count_q >= cap_eff) begin
									stat_q  <= imhq_pkg::ST_FULL;
									state_q <= S_DONE;
								end else begin
									stat_q  <= imhq_pkg::ST_OK;
									cur_q   <= '{req.in_vertex, req.in_dist, req.in_prev};
									pos_q   <= AW'(count_q);
									count_q <= count_q + CW'(1);
									state_q <= S_UPA;
								end
							end
							imhq_pkg::MODE_EXTRACT, imhq_pkg::MODE_PEEK: begin
								if (count_q == '0) begin
									stat_q  <= imhq_pkg::ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									stat_q  <= imhq_pkg::ST_OK;
									pos_q   <= '0;
									state_q <= S_PEEK;
								end
							end
							imhq_pkg::MODE_DECR, imhq_pkg::MODE_DELETE,
							imhq_pkg::MODE_SETPREV: begin
								if (CW'(req.in_slot) >= count_q) begin
									stat_q  <= imhq_pkg::ST_RANGE;
									state_q <= S_DONE;
								end else begin
									stat_q  <= imhq_pkg::ST_OK;
									pos_q   <= req.in_slot;
									state_q <= S_RD;
								end
							end
							imhq_pkg::MODE_FIND: begin
								stat_q  <= imhq_pkg::ST_OK;
								state_q <= S_FIND;
							end
							default: begin
								stat_q  <= imhq_pkg::ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PEEK: begin
					// raddr was slot in idle; the default read address here is 0, so reread root
					state_q <= S_RD;
				end
				S_RD: begin
					unique case (req_q.mode)
						imhq_pkg::MODE_DECR: begin
							cur_q   <= '{rdata.vertex, req_q.in_dist, rdata.prev};
							state_q <= S_UPA;
						end
						imhq_pkg::MODE_DELETE: begin
							cur_q   <= rdata;
							force_q <= 1'b1;
							state_q <= S_UPA;
						end
						imhq_pkg::MODE_EXTRACT: begin
							res_q <= rdata;
							state_q <= S_RT0;
						end
						imhq_pkg::MODE_PEEK: begin
							res_q <= rdata;
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_UPA: begin
					if (pos_q == '0) state_q <= S_UPC;
					else state_q <= S_UPB;
				end
				S_UPB: begin
					if (force_q || (rdata.distance > cur_q.distance)) begin
						pos_q <= parent;
						state_q <= S_UPA;
					end else state_q <= S_UPC;
				end
				S_UPC: begin
					if (force_q) state_q <= S_RT0;
					else state_q <= S_DONE;
				end
				S_RT0: begin
					count_q <= count_q - CW'(1);
					state_q <= S_RT1;
				end
				S_RT1: begin
					cur_q <= rdata;
					pos_q <= '0;
					state_q <= S_DNA;
				end
				S_DNA: begin
					has_l_q <= child_l < count_q;
					state_q <= S_DNB;
				end
				S_DNB: begin
					lch_q <= rdata;
					sel_q <= dn_left ? child_l[AW-1:0] : pos_q;
					state_q <= S_DNC;
				end
				S_DNC: begin
					if (dn_right) begin
						pos_q <= child_r[AW-1:0];
						state_q <= S_DNA;
					end else if (sel_q != pos_q) begin
						pos_q <= sel_q;
						state_q <= S_DNA;
					end else state_q <= S_DONE;
				end
				S_FIND: begin
					if (scan_q >= count_q) state_q <= S_DONE;
					else begin
						scan_q <= scan_q + CW'(1);
						state_q <= S_FWAIT;
					end
				end
				S_FWAIT: begin
					if (rdata.vertex == req_q.in_vertex) begin
						found_q <= 1'b1;
						fslot_q <= AW'(scan_q - CW'(1));
						state_q <= S_DONE;
					end else state_q <= S_FIND;
				end
				S_DONE: begin
					rsp.out_vertex  <= (req_q.mode == imhq_pkg::MODE_DELETE) ? '0 : res_q.vertex;
					rsp.out_dist    <= (req_q.mode == imhq_pkg::MODE_DELETE) ? '0 : res_q.distance;
					rsp.out_prev    <= (req_q.mode == imhq_pkg::MODE_DELETE) ? '0 : res_q.prev;
					rsp.out_slot    <= fslot_q;
					rsp.out_found   <= found_q;
					rsp.entry_count <= count_q;
					rsp.status      <= stat_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(imhq_pkg::Depth)) else $error("count overflow");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !busy) else $error("cfg while busy");
`endif
endmodule

[sim/indexed_min_heap_queue_tb.sv]
// indexed_min_heap_queue_tb: self-checking bench for the indexed min-heap queue
// drives random and directed requests, predicts each response with a local heap
// depends on imhq_pkg and the indexed_min_heap_queue rtl
module indexed_min_heap_queue_tb;

	typedef struct packed {
		logic            is_cfg;
		logic [10:0]     cap;
		logic            drain;
		imhq_pkg::req_t  rq;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	imhq_pkg::req_t req = '0;
	logic done;
	imhq_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [10:0] cfg_data = 11'd1024;

	stim_t pending_q[$];
	imhq_pkg::rsp_t expected_rsp_q[$];
	imhq_pkg::entry_t heap_model[imhq_pkg::Depth];
	int unsigned heap_count = 0;
	int unsigned heap_cap = 1024;
	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_items = 0;
	int unsigned n_cfg = 0;
	logic stim_done = 1'b0;

	logic item_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int unsigned quiet_left = 0;
	int unsigned cycle_no = 0;

	indexed_min_heap_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void heap_swap(int unsigned a, int unsigned b);
		imhq_pkg::entry_t t;
		t = heap_model[a];
		heap_model[a] = heap_model[b];
		heap_model[b] = t;
	endfunction

	function automatic void heap_up(int unsigned i, bit forced);
		int unsigned p;
		while (i != 0) begin
			p = (i - 1) / 2;
			if (!forced && !(heap_model[p].distance > heap_model[i].distance))
				break;
			heap_swap(i, p);
			i = p;
		end
	endfunction

	function automatic void heap_down(int unsigned i);
		int unsigned l, r, s;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			s = i;
			if (l < heap_count && heap_model[l].distance < heap_model[s].distance)
				s = l;
			if (r < heap_count && heap_model[r].distance < heap_model[s].distance)
				s = r;
			if (s == i)
				break;
			heap_swap(i, s);
			i = s;
		end
	endfunction

	function automatic imhq_pkg::entry_t heap_pop();
		imhq_pkg::entry_t root;
		root = heap_model[0];
		heap_model[0] = heap_model[heap_count - 1];
		heap_count--;
		if (heap_count > 1)
			heap_down(0);
		return root;
	endfunction

	function automatic imhq_pkg::rsp_t predict_heap_op(imhq_pkg::req_t r);
		imhq_pkg::rsp_t o;
		imhq_pkg::entry_t e;
		int unsigned lim;
		o = '0;
		lim = heap_cap > imhq_pkg::Depth ? imhq_pkg::Depth : heap_cap;
		case (imhq_pkg::mode_t'(r.mode))
			imhq_pkg::MODE_INSERT: begin
				if (heap_count >= lim) begin
					o.status = imhq_pkg::ST_FULL;
				end else begin
					heap_model[heap_count] = '{r.in_vertex, r.in_dist, r.in_prev};
					heap_count++;
					heap_up(heap_count - 1, 1'b0);
				end
			end
			imhq_pkg::MODE_EXTRACT, imhq_pkg::MODE_PEEK: begin
				if (heap_count == 0) begin
					o.status = imhq_pkg::ST_EMPTY;
				end else begin
					e = (r.mode == imhq_pkg::MODE_EXTRACT) ? heap_pop() : heap_model[0];
					o.out_vertex = e.vertex;
					o.out_dist = e.distance;
					o.out_prev = e.prev;
				end
			end
			imhq_pkg::MODE_DECR: begin
				if (r.in_slot >= heap_count) begin
					o.status = imhq_pkg::ST_RANGE;
				end else begin
					heap_model[r.in_slot].distance = r.in_dist;
					heap_up(r.in_slot, 1'b0);
				end
			end
			imhq_pkg::MODE_DELETE: begin
				if (r.in_slot >= heap_count) begin
					o.status = imhq_pkg::ST_RANGE;
				end else begin
					heap_up(r.in_slot, 1'b1);
					void'(heap_pop());
				end
			end
			imhq_pkg::MODE_FIND: begin
				for (int unsigned i = 0; i < heap_count; i++) begin
					if (heap_model[i].vertex == r.in_vertex) begin
						o.out_found = 1'b1;
						o.out_slot = i[9:0];
						break;
					end
				end
			end
			imhq_pkg::MODE_SETPREV: begin
				if (r.in_slot >= heap_count)
					o.status = imhq_pkg::ST_RANGE;
				else
					heap_model[r.in_slot].prev = r.in_prev;
			end
			default: ;
		endcase
		o.entry_count = heap_count[10:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic imhq_pkg::req_t make_req(imhq_pkg::mode_t m, int unsigned slot,
			logic [15:0] v, logic [31:0] d, logic [15:0] p);
		imhq_pkg::req_t r;
		r.mode = m;
		r.in_slot = slot[9:0];
		r.in_vertex = v;
		r.in_dist = d;
		r.in_prev = p;
		return r;
	endfunction

	task automatic add_req(imhq_pkg::req_t r);
		stim_t s;
		s = '0;
		s.rq = r;
		pending_q.push_back(s);
		n_items++;
	endtask

	task automatic add_cap(int unsigned c);
		stim_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.cap = c[10:0];
		pending_q.push_back(s);
	endtask

	task automatic add_drain();
		stim_t s;
		s = '0;
		s.drain = 1'b1;
		pending_q.push_back(s);
	endtask

	// random item; est tracks an estimate of heap size to steer slots
	function automatic imhq_pkg::req_t rand_req(int unsigned est, int unsigned vspan);
		imhq_pkg::req_t r;
		int unsigned k;
		r.in_vertex = (vspan == 0) ? 16'($urandom) : 16'($urandom_range(vspan));
		r.in_dist = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(64));
		r.in_prev = 16'($urandom);
		r.in_slot = ($urandom_range(9) == 0 || est == 0) ? 10'($urandom)
			: 10'($urandom_range(est - 1));
		k = $urandom_range(99);
		if (k < 34) r.mode = imhq_pkg::MODE_INSERT;
		else if (k < 52) r.mode = imhq_pkg::MODE_EXTRACT;
		else if (k < 64) r.mode = imhq_pkg::MODE_DECR;
		else if (k < 74) r.mode = imhq_pkg::MODE_DELETE;
		else if (k < 82) r.mode = imhq_pkg::MODE_FIND;
		else if (k < 90) r.mode = imhq_pkg::MODE_SETPREV;
		else if (k < 98) r.mode = imhq_pkg::MODE_PEEK;
		else r.mode = imhq_pkg::MODE_NONE;
		return r;
	endfunction

	initial begin
		int unsigned est;
		int unsigned caps[6];
		imhq_pkg::req_t r;
		// directed part
		add_req(make_req(imhq_pkg::MODE_EXTRACT, 0, 0, 0, 0));
		add_req(make_req(imhq_pkg::MODE_PEEK, 0, 0, 0, 0));
		add_req(make_req(imhq_pkg::MODE_DECR, 0, 0, 0, 0));
		add_req(make_req(imhq_pkg::MODE_DELETE, 1023, 0, 0, 0));
		add_req(make_req(imhq_pkg::MODE_SETPREV, 0, 0, 0, 16'hffff));
		add_req(make_req(imhq_pkg::MODE_FIND, 0, 16'hffff, 0, 0));
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'hffff, 32'hffffffff, 16'hffff));
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'h0000, 32'h0, 16'h0));
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'h1234, 32'd5, 16'h1));
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'h1235, 32'd5, 16'h2));
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'h1236, 32'd5, 16'h3));
		add_req(make_req(imhq_pkg::MODE_DECR, 3, 0, 32'd100, 0));
		add_req(make_req(imhq_pkg::MODE_DECR, 4, 0, 32'd1, 0));
		add_req(make_req(imhq_pkg::MODE_DELETE, 4, 0, 0, 0));
		add_req(make_req(imhq_pkg::MODE_FIND, 0, 16'h1236, 0, 0));
		add_req(make_req(imhq_pkg::MODE_FIND, 0, 16'h7777, 0, 0));
		add_req(make_req(imhq_pkg::MODE_SETPREV, 1, 0, 0, 16'habcd));
		add_req(make_req(imhq_pkg::MODE_SETPREV, 9, 0, 0, 16'habcd));
		add_req(make_req(imhq_pkg::MODE_NONE, 1023, 16'hffff, 32'hffffffff, 16'hffff));
		add_req(make_req(imhq_pkg::MODE_PEEK, 0, 0, 0, 0));
		add_req(make_req(imhq_pkg::MODE_EXTRACT, 0, 0, 0, 0));
		add_drain();
		add_cap(2);
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'h9, 32'd9, 16'h9));
		add_req(make_req(imhq_pkg::MODE_INSERT, 0, 16'ha, 32'd10, 16'ha));
		add_drain();
		// random phases under several capacities
		caps = '{1, 0, 2047, 8, 1024, 40};
		est = 5;
		foreach (caps[c]) begin
			add_cap(caps[c]);
			repeat (285) begin
				r = rand_req(est, (c % 2 == 0) ? 0 : 31);
				if (r.mode == imhq_pkg::MODE_INSERT && est < 60) est++;
				if ((r.mode == imhq_pkg::MODE_EXTRACT || r.mode == imhq_pkg::MODE_DELETE)
					&& est > 0) est--;
				add_req(r);
			end
			add_drain();
		end
		stim_done = 1'b1;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		item_taken <= arst_n && start && !busy;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		cycle_no <= cycle_no + 1;
	end

	// driver: drop a taken item and feed the next one at the falling edge
	always @(negedge clk) begin
		stim_t s;
		logic start_nx;
		logic valid_nx;
		if (arst_n) begin
			start_nx = start && !item_taken;
			valid_nx = cfg_valid && !cfg_taken;
			if (!start_nx && !valid_nx) begin
				if (quiet_left != 0) begin
					quiet_left <= quiet_left - 1;
				end else if (pending_q.size() != 0) begin
					s = pending_q[0];
					if (s.drain) begin
						if (expected_rsp_q.size() == 0 && !busy) begin
							void'(pending_q.pop_front());
							quiet_left <= 80;
						end
					end else if (cycle_no % 3000 > 900 && $urandom_range(99) < 19) begin
						// random idle cycle
					end else if (s.is_cfg) begin
						void'(pending_q.pop_front());
						heap_cap = {21'd0, s.cap};
						cfg_data <= s.cap;
						valid_nx = 1'b1;
						n_cfg++;
					end else begin
						void'(pending_q.pop_front());
						expected_rsp_q.push_back(predict_heap_op(s.rq));
						req <= s.rq;
						start_nx = 1'b1;
					end
				end
			end
			start <= start_nx;
			cfg_valid <= valid_nx;
		end
	end

	// monitor
	always @(posedge clk) begin
		imhq_pkg::rsp_t w;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(rsp), 64'd0);
			end else begin
				w = expected_rsp_q.pop_front();
				n_checked++;
				if (rsp.out_vertex !== w.out_vertex)
					report_mismatch("out_vertex", 64'(rsp.out_vertex), 64'(w.out_vertex));
				if (rsp.out_dist !== w.out_dist)
					report_mismatch("out_dist", 64'(rsp.out_dist), 64'(w.out_dist));
				if (rsp.out_prev !== w.out_prev)
					report_mismatch("out_prev", 64'(rsp.out_prev), 64'(w.out_prev));
				if (rsp.out_slot !== w.out_slot)
					report_mismatch("out_slot", 64'(rsp.out_slot), 64'(w.out_slot));
				if (rsp.out_found !== w.out_found)
					report_mismatch("out_found", 64'(rsp.out_found), 64'(w.out_found));
				if (rsp.entry_count !== w.entry_count)
					report_mismatch("entry_count", 64'(rsp.entry_count), 64'(w.entry_count));
				if (rsp.status !== w.status)
					report_mismatch("status", 64'(rsp.status), 64'(w.status));
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_q.size() == 0 && !start && !cfg_valid);
		wait (expected_rsp_q.size() == 0);
		repeat (100) @(posedge clk);
		if (expected_rsp_q.size() != 0)
			report_mismatch("results never arrived", 64'(expected_rsp_q.size()), 64'd0);
		$display("covered %0d requests over %0d capacity settings, %0d results checked",
			n_items, n_cfg, n_checked);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#200000000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

[files.f]
rtl/imhq_pkg.sv
rtl/imhq_ram.sv
rtl/indexed_min_heap_queue.sv
sim/indexed_min_heap_queue_tb.sv
